// ===== rtl/core/smri_pkg.sv =====
// ----------------------------------------------------------------------------
// smri_pkg
// shared types and constants of the shutter motor reversal interlock
// ----------------------------------------------------------------------------
package smri_pkg;

   // widths
   localparam int DEAD_TIME_WIDTH = 16;
   localparam int FUNC_WIDTH      = 3;
   localparam int TIMER_WIDTH_DEF = 16;

   // dead time register
   localparam logic [DEAD_TIME_WIDTH-1:0] DEAD_TIME_MIN   = 16'd500;
   localparam logic [DEAD_TIME_WIDTH-1:0] DEAD_TIME_RESET = 16'd1000;

   // command codes
   localparam logic [FUNC_WIDTH-1:0] CMD_NONE    = 3'd0;
   localparam logic [FUNC_WIDTH-1:0] CMD_UP      = 3'd1;
   localparam logic [FUNC_WIDTH-1:0] CMD_DOWN    = 3'd2;
   localparam logic [FUNC_WIDTH-1:0] CMD_STOP    = 3'd3;
   localparam logic [FUNC_WIDTH-1:0] CMD_RESTART = 3'd4;

   typedef enum logic [2:0] {
      ST_IDLE            = 3'd0,
      ST_STOP_AFTER_DOWN = 3'd1,
      ST_STOP_AFTER_UP   = 3'd2,
      ST_GOING_UP        = 3'd3,
      ST_GOING_DOWN      = 3'd4,
      ST_WAIT_DOWN       = 3'd5,
      ST_WAIT_UP         = 3'd6
   } motor_state_type;

   // one result beat
   typedef struct packed {
      logic            relay_up;
      logic            relay_down;
      motor_state_type motor_state;
      logic            state_changed;
   } rsp_type;

endpackage

// ===== rtl/core/smri_fsm.sv =====
// ----------------------------------------------------------------------------
// smri_fsm
// dead time register, dead-time timer and motor state machine
// ----------------------------------------------------------------------------
module smri_fsm
   import smri_pkg::*;
#(
   parameter int TIMER_WIDTH = TIMER_WIDTH_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_wr_en,
   input  logic [DEAD_TIME_WIDTH-1:0] csr_wr_data,
   input  logic                       step,
   input  logic [FUNC_WIDTH-1:0]      func,
   input  logic                       tick,
   output rsp_type                    result
);

   localparam int LIM_WIDTH = (TIMER_WIDTH > DEAD_TIME_WIDTH) ? TIMER_WIDTH : DEAD_TIME_WIDTH;

   logic [DEAD_TIME_WIDTH-1:0] dead_time_ff, dead_time_in;
   motor_state_type            state_ff, state_in;
   logic [TIMER_WIDTH-1:0]     elapsed_ff, elapsed_in;

   logic [LIM_WIDTH-1:0]   dt_ext, tmax_ext;
   logic [TIMER_WIDTH-1:0] limit, counted;
   logic                   timeout, no_cmd, changed, leaving_motion;

   // dead time clamped to what the timer can hold
   assign dt_ext   = LIM_WIDTH'(dead_time_ff);
   assign tmax_ext = LIM_WIDTH'({TIMER_WIDTH{1'b1}});
   assign limit    = (dt_ext < tmax_ext) ? TIMER_WIDTH'(dt_ext) : {TIMER_WIDTH{1'b1}};

   assign dead_time_in = (csr_wr_data < DEAD_TIME_MIN) ? DEAD_TIME_RESET : csr_wr_data;

   always_comb begin
      counted = elapsed_ff;
      if (tick && (elapsed_ff < limit)) begin
         counted = elapsed_ff + 1'b1;
      end
      if (func == CMD_RESTART) begin
         counted = '0;
      end
   end

   assign timeout = counted >= limit;
   assign no_cmd  = (func != CMD_UP) && (func != CMD_DOWN) && (func != CMD_STOP);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (func == CMD_UP) state_in = ST_GOING_UP;
            else if (func == CMD_DOWN) state_in = ST_GOING_DOWN;
         end
         ST_STOP_AFTER_DOWN: begin
            if (func == CMD_UP) state_in = ST_WAIT_UP;
            else if (func == CMD_DOWN) state_in = ST_GOING_DOWN;
            else if (no_cmd && timeout) state_in = ST_IDLE;
         end
         ST_STOP_AFTER_UP: begin
            if (func == CMD_UP) state_in = ST_GOING_UP;
            else if (func == CMD_DOWN) state_in = ST_WAIT_DOWN;
            else if (no_cmd && timeout) state_in = ST_IDLE;
         end
         ST_GOING_UP: begin
            if (func == CMD_DOWN) state_in = ST_WAIT_DOWN;
            else if (func == CMD_STOP) state_in = ST_STOP_AFTER_UP;
         end
         ST_GOING_DOWN: begin
            if (func == CMD_UP) state_in = ST_WAIT_UP;
            else if (func == CMD_STOP) state_in = ST_STOP_AFTER_DOWN;
         end
         ST_WAIT_DOWN: begin
            if (func == CMD_STOP) state_in = ST_STOP_AFTER_UP;
            else if (no_cmd && timeout) state_in = ST_GOING_DOWN;
         end
         ST_WAIT_UP: begin
            if (func == CMD_STOP) state_in = ST_STOP_AFTER_DOWN;
            else if (no_cmd && timeout) state_in = ST_GOING_UP;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign changed        = state_in != state_ff;
   assign leaving_motion = changed && ((state_ff == ST_GOING_UP) || (state_ff == ST_GOING_DOWN));
   assign elapsed_in     = leaving_motion ? '0 : counted;

   always_ff @(posedge clock) begin
      if (reset) begin
         dead_time_ff <= DEAD_TIME_RESET;
         state_ff     <= ST_IDLE;
         elapsed_ff   <= '0;
      end else begin
         if (csr_wr_en) begin
            dead_time_ff <= dead_time_in;
         end
         if (step) begin
            state_ff   <= state_in;
            elapsed_ff <= elapsed_in;
         end
      end
   end

   assign result.relay_up      = state_in == ST_GOING_UP;
   assign result.relay_down    = state_in == ST_GOING_DOWN;
   assign result.motor_state   = state_in;
   assign result.state_changed = changed;

endmodule

// ===== rtl/core/smri_out.sv =====
// ----------------------------------------------------------------------------
// smri_out
// result register with a skid entry behind it
// ----------------------------------------------------------------------------
module smri_out
   import smri_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  rsp_type push_data,
   output logic    full,
   output logic    out_valid,
   input  logic    out_stall,
   output rsp_type out_data
);

   rsp_type main_ff, main_in, skid_ff, skid_in;
   logic    main_valid_ff, main_valid_in, skid_valid_ff, skid_valid_in;
   logic    pop;

   assign pop = main_valid_ff && !out_stall;

   always_comb begin
      main_in       = main_ff;
      main_valid_in = main_valid_ff;
      skid_in       = skid_ff;
      skid_valid_in = skid_valid_ff;
      if (pop || !main_valid_ff) begin
         if (skid_valid_ff) begin
            main_in       = skid_ff;
            main_valid_in = 1'b1;
            skid_valid_in = 1'b0;
         end else if (push) begin
            main_in       = push_data;
            main_valid_in = 1'b1;
         end else begin
            main_valid_in = 1'b0;
         end
      end else if (push) begin
         skid_in       = push_data;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

   assign full      = skid_valid_ff;
   assign out_valid = main_valid_ff;
   assign out_data  = main_ff;

endmodule

// ===== rtl/core/shutter_motor_reversal_interlock.sv =====
// ----------------------------------------------------------------------------
// shutter_motor_reversal_interlock
// up/down relay control of a shutter motor with dead time before reversal
// ----------------------------------------------------------------------------
//
//  channel  ports                          direction  beat
//  req      req_valid/req_stall            in         func, tick
//  rsp      rsp_valid/rsp_stall            out        relays, state, changed
//  csr      csr_wr_en/csr_wr_data          in         dead time write
//
//  one beat per cycle in while req_stall is low, one result per beat; each
//  result is held in the result register, or in its skid entry while stalled
//  reset is synchronous: idle, result invalid, timer zero, dead time 1000
//  req_stall rises only when the result register and its skid entry are both
//  full, so a beat is still taken in the cycle a result is first stalled
//
module shutter_motor_reversal_interlock
   import smri_pkg::*;
#(
   parameter int TIMER_WIDTH = TIMER_WIDTH_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   // command beats
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [FUNC_WIDTH-1:0]      req_func,
   input  logic                       req_tick,
   // result beats
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic                       rsp_relay_up,
   output logic                       rsp_relay_down,
   output logic [2:0]                 rsp_motor_state,
   output logic                       rsp_state_changed,
   // dead time register
   input  logic                       csr_wr_en,
   input  logic [DEAD_TIME_WIDTH-1:0] csr_wr_data
);

   logic    req_take;
   logic    out_full;
   rsp_type step_result;
   rsp_type rsp_data;

   // a beat goes in whenever the skid entry is free
   assign req_stall = out_full;
   assign req_take  = req_valid && !out_full;

   // state machine and timer advance once per taken beat
   smri_fsm #(
      .TIMER_WIDTH(TIMER_WIDTH)
   ) u_fsm (
      .clock      (clock),
      .reset      (reset),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .step       (req_take),
      .func       (req_func),
      .tick       (req_tick),
      .result     (step_result)
   );

   // result register plus skid entry
   smri_out u_out (
      .clock    (clock),
      .reset    (reset),
      .push     (req_take),
      .push_data(step_result),
      .full     (out_full),
      .out_valid(rsp_valid),
      .out_stall(rsp_stall),
      .out_data (rsp_data)
   );

   assign rsp_relay_up      = rsp_data.relay_up;
   assign rsp_relay_down    = rsp_data.relay_down;
   assign rsp_motor_state   = 3'(rsp_data.motor_state);
   assign rsp_state_changed = rsp_data.state_changed;

endmodule
